// ===== sv/sseps_pkg.sv =====
// ----------------------------------------------------------------------------
// sseps_pkg
// Types, character codes and helper functions for the event stream parser.
// ----------------------------------------------------------------------------
package sseps_pkg;

  typedef enum logic [1:0] {
    PH_NAME  = 2'd0,
    PH_VALUE = 2'd1,
    PH_SKIP  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    VK_NONE  = 2'd0,
    VK_DATA  = 2'd1,
    VK_EVENT = 2'd2,
    VK_ID    = 2'd3
  } vkind_t;

  typedef enum logic [2:0] {
    TK_DATA       = 3'd0,
    TK_TYPE_BEGIN = 3'd1,
    TK_TYPE_BYTE  = 3'd2,
    TK_TYPE_CLEAR = 3'd3,
    TK_ID_BEGIN   = 3'd4,
    TK_ID_BYTE    = 3'd5,
    TK_ID_CLEAR   = 3'd6,
    TK_DISPATCH   = 3'd7
  } tok_kind_t;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_V     = 8'h76;

  // candidate bits
  localparam int unsigned M_DATA  = 0;
  localparam int unsigned M_EVENT = 1;
  localparam int unsigned M_ID    = 2;

  localparam logic [2:0] NAME_MAX = 3'd7;

  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] data;
  } tok_t;

  // up to two tokens from one beat
  typedef struct packed {
    tok_t       t0;
    tok_t       t1;
    logic [1:0] n;
  } emit_t;

  function automatic emit_t push(emit_t e, tok_kind_t k, logic [7:0] b);
    emit_t r;
    r = e;
    if (e.n == 2'd0) begin
      r.t0.kind = k;
      r.t0.data = b;
      r.n       = 2'd1;
    end else if (e.n == 2'd1) begin
      r.t1.kind = k;
      r.t1.data = b;
      r.n       = 2'd2;
    end
    return r;
  endfunction

  // which names still agree with byte c at position p
  function automatic logic [2:0] name_hit(logic [2:0] p, logic [7:0] c);
    logic [2:0] m;
    m = 3'b000;
    case (p)
      3'd0: begin
        m[M_DATA]  = (c == CH_D);
        m[M_EVENT] = (c == CH_E);
        m[M_ID]    = (c == CH_I);
      end
      3'd1: begin
        m[M_DATA]  = (c == CH_A);
        m[M_EVENT] = (c == CH_V);
        m[M_ID]    = (c == CH_D);
      end
      3'd2: begin
        m[M_DATA]  = (c == CH_T);
        m[M_EVENT] = (c == CH_E);
      end
      3'd3: begin
        m[M_DATA]  = (c == CH_A);
        m[M_EVENT] = (c == CH_N);
      end
      3'd4: begin
        m[M_EVENT] = (c == CH_T);
      end
      default: m = 3'b000;
    endcase
    return m;
  endfunction

  function automatic vkind_t name_kind(logic [2:0] len, logic [2:0] match);
    vkind_t k;
    if (len == 3'd4 && match[M_DATA]) k = VK_DATA;
    else if (len == 3'd5 && match[M_EVENT]) k = VK_EVENT;
    else if (len == 3'd2 && match[M_ID]) k = VK_ID;
    else k = VK_NONE;
    return k;
  endfunction

  function automatic logic [2:0] len_inc(logic [2:0] len);
    return (len == NAME_MAX) ? len : len + 3'd1;
  endfunction

endpackage

// ===== sv/sseps_in_if.sv =====
// ----------------------------------------------------------------------------
// sseps_in_if
// Stream byte channel: one byte or an end-of-stream flush per beat.
// ----------------------------------------------------------------------------
interface sseps_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] byte_value;

  modport source (output valid, output operation, output byte_value, input ready);
  modport sink   (input valid, input operation, input byte_value, output ready);
endinterface

// ===== sv/sseps_out_if.sv =====
// ----------------------------------------------------------------------------
// sseps_out_if
// Token channel: one tagged token per beat.
// ----------------------------------------------------------------------------
interface sseps_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [7:0] token_byte;
  logic       last;

  modport source (output valid, output token_kind, output token_byte, output last,
                  input ready);
  modport sink   (input valid, input token_kind, input token_byte, input last,
                  output ready);
endinterface

// ===== sv/sseps_tok_queue.sv =====
// ----------------------------------------------------------------------------
// sseps_tok_queue
// Four-entry token queue: takes up to two tokens a cycle, drains one a cycle while tokens.ready is high.
// ----------------------------------------------------------------------------
module sseps_tok_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  sseps_pkg::emit_t push_data,
  output logic           space_ok,
  sseps_out_if.source    tokens
);
  import sseps_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef struct packed {
    tok_t tok;
    logic last;
  } qent_t;

  qent_t         mem [DEPTH];
  logic [AW-1:0] wr;
  logic [AW-1:0] rd;
  logic [AW:0]   cnt;
  logic [AW:0]   cnt_next;
  logic [1:0]    n_push;
  logic          pop;

  assign n_push   = push_valid ? push_data.n : 2'd0;
  assign pop      = tokens.valid && tokens.ready;
  assign cnt_next = cnt + (AW+1)'(n_push) - (AW+1)'(pop);
  assign space_ok = (cnt <= (AW+1)'(DEPTH - 2));

  assign tokens.valid      = (cnt != '0);
  assign tokens.token_kind = mem[rd].tok.kind;
  assign tokens.token_byte = mem[rd].tok.data;
  assign tokens.last       = mem[rd].last;

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr] <= '{tok: push_data.t0, last: (n_push == 2'd1)};
    end
    if (n_push == 2'd2) begin
      mem[wr + AW'(1)] <= '{tok: push_data.t1, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr  <= '0;
      rd  <= '0;
      cnt <= '0;
    end else begin
      wr  <= wr + AW'(n_push);
      rd  <= rd + AW'(pop);
      cnt <= cnt_next;
    end
  end

endmodule

// ===== sv/sse_event_stream_parser_unit.sv =====
// ----------------------------------------------------------------------------
// sse_event_stream_parser_unit
// Server-Sent Events line parser that streams tagged tokens.
// ----------------------------------------------------------------------------
// Takes one stream byte (or an end-of-stream flush) per cycle and emits zero,
// one or two tokens for it; the final token of each beat has last set. The
// line state is updated in the cycle a beat is taken and its tokens are
// written into a four-entry queue, from whose registers they are offered.
// stream.ready is high while the queue has two free entries: one byte per
// cycle is sustained while each byte yields at most one token and the token
// side keeps up; a beat that yields two tokens (a held CR followed by a value
// byte, or a flush) needs two pops on the token side.
module sse_event_stream_parser_unit (
  input  logic        clk,
  input  logic        rst,
  sseps_in_if.sink    stream,
  sseps_out_if.source tokens
);
  import sseps_pkg::*;

  phase_t     line_phase,  line_phase_next;
  logic [2:0] name_length, name_length_next;
  logic [2:0] name_match,  name_match_next;
  vkind_t     value_kind,  value_kind_next;
  logic       first_value_byte, first_value_byte_next;
  logic       held_cr,     held_cr_next;
  logic       data_present, data_present_next;
  emit_t      emit;
  logic       accept;
  logic       space_ok;

  assign stream.ready = space_ok;
  assign accept       = stream.valid && stream.ready;

  always_comb begin
    logic [7:0] c;
    logic [2:0] len_a;
    logic [2:0] match_a;
    logic       dp;
    logic       end_ln;
    vkind_t     k;
    vkind_t     kb;

    c       = stream.byte_value;
    emit    = '0;
    end_ln  = 1'b0;
    dp      = data_present;
    k       = VK_NONE;

    line_phase_next       = line_phase;
    name_length_next      = name_length;
    name_match_next       = name_match;
    value_kind_next       = value_kind;
    first_value_byte_next = first_value_byte;
    held_cr_next          = held_cr;

    // held CR folded into the name
    len_a   = held_cr ? len_inc(name_length) : name_length;
    match_a = held_cr ? 3'b000 : name_match;

    // kind for a bare name, with or without the held CR folded in
    kb = (stream.operation == OP_BYTE && c == CH_LF) ?
         name_kind(name_length, name_match) : name_kind(len_a, match_a);

    if (stream.operation == OP_FLUSH) begin
      if (line_phase == PH_NAME) begin
        if (len_a != 3'd0) begin
          k = kb;
        end
      end else if (line_phase == PH_VALUE && held_cr) begin
        case (value_kind)
          VK_DATA: begin
            emit = push(emit, TK_DATA, CH_CR);
            dp   = 1'b1;
          end
          VK_EVENT: emit = push(emit, TK_TYPE_BYTE, CH_CR);
          VK_ID:    emit = push(emit, TK_ID_BYTE, CH_CR);
          default: ;
        endcase
      end
      case (k)
        VK_DATA:  if (dp) emit = push(emit, TK_DATA, CH_LF);
        VK_EVENT: emit = push(emit, TK_TYPE_CLEAR, 8'h00);
        VK_ID:    emit = push(emit, TK_ID_CLEAR, 8'h00);
        default: ;
      endcase
      if (dp) begin
        emit = push(emit, TK_DISPATCH, 8'h00);
        dp   = 1'b0;
      end
      end_ln = 1'b1;
    end else begin
      case (line_phase)
        PH_NAME: begin
          if (c == CH_LF) begin
            if (name_length == 3'd0) begin
              if (dp) begin
                emit = push(emit, TK_DISPATCH, 8'h00);
                dp   = 1'b0;
              end
            end else begin
              k = kb;
            end
            end_ln = 1'b1;
          end else begin
            name_length_next = len_a;
            name_match_next  = match_a;
            held_cr_next     = 1'b0;
            if (c == CH_CR) begin
              held_cr_next = 1'b1;
            end else if (c == CH_NUL) begin
              if (len_a == 3'd0) begin
                if (dp) begin
                  emit = push(emit, TK_DISPATCH, 8'h00);
                  dp   = 1'b0;
                end
              end else begin
                k = kb;
              end
              line_phase_next = PH_SKIP;
            end else if (c == CH_COLON) begin
              case (kb)
                VK_DATA:  if (dp) emit = push(emit, TK_DATA, CH_LF);
                VK_EVENT: emit = push(emit, TK_TYPE_BEGIN, 8'h00);
                VK_ID:    emit = push(emit, TK_ID_BEGIN, 8'h00);
                default: ;
              endcase
              if (kb == VK_NONE) begin
                line_phase_next = PH_SKIP;
              end else begin
                line_phase_next       = PH_VALUE;
                value_kind_next       = kb;
                first_value_byte_next = 1'b1;
              end
            end else begin
              name_match_next  = match_a & name_hit(len_a, c);
              name_length_next = len_inc(len_a);
            end
          end
          // bare name resolution
          case (k)
            VK_DATA:  if (dp) emit = push(emit, TK_DATA, CH_LF);
            VK_EVENT: emit = push(emit, TK_TYPE_CLEAR, 8'h00);
            VK_ID:    emit = push(emit, TK_ID_CLEAR, 8'h00);
            default: ;
          endcase
        end
        PH_VALUE: begin
          if (c == CH_LF) begin
            end_ln = 1'b1;
          end else begin
            if (held_cr) begin
              held_cr_next = 1'b0;
              case (value_kind)
                VK_DATA: begin
                  emit = push(emit, TK_DATA, CH_CR);
                  dp   = 1'b1;
                end
                VK_EVENT: emit = push(emit, TK_TYPE_BYTE, CH_CR);
                VK_ID:    emit = push(emit, TK_ID_BYTE, CH_CR);
                default: ;
              endcase
            end
            if (c == CH_CR) begin
              first_value_byte_next = 1'b0;
              held_cr_next          = 1'b1;
            end else if (c == CH_NUL) begin
              line_phase_next = PH_SKIP;
            end else if (c == CH_SPACE && first_value_byte) begin
              first_value_byte_next = 1'b0;
            end else begin
              first_value_byte_next = 1'b0;
              case (value_kind)
                VK_DATA: begin
                  emit = push(emit, TK_DATA, c);
                  dp   = 1'b1;
                end
                VK_EVENT: emit = push(emit, TK_TYPE_BYTE, c);
                VK_ID:    emit = push(emit, TK_ID_BYTE, c);
                default: ;
              endcase
            end
          end
        end
        default: begin
          if (c == CH_LF) end_ln = 1'b1;
        end
      endcase
    end

    if (end_ln) begin
      line_phase_next       = PH_NAME;
      name_length_next      = 3'd0;
      name_match_next       = 3'b111;
      value_kind_next       = VK_NONE;
      first_value_byte_next = 1'b1;
      held_cr_next          = 1'b0;
    end
    data_present_next = dp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_phase       <= PH_NAME;
      name_length      <= 3'd0;
      name_match       <= 3'b111;
      value_kind       <= VK_NONE;
      first_value_byte <= 1'b1;
      held_cr          <= 1'b0;
      data_present     <= 1'b0;
    end else if (accept) begin
      line_phase       <= line_phase_next;
      name_length      <= name_length_next;
      name_match       <= name_match_next;
      value_kind       <= value_kind_next;
      first_value_byte <= first_value_byte_next;
      held_cr          <= held_cr_next;
      data_present     <= data_present_next;
    end
  end

  sseps_tok_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (accept),
    .push_data  (emit),
    .space_ok   (space_ok),
    .tokens     (tokens)
  );

endmodule
